// ===== rtl/qam_pkg.sv =====
// package: opcodes, widths, a saturation helper and a result check for the q8.8 alu/mac
package qam_pkg;

    localparam int OP_W       = 4;
    localparam int DATA_W     = 16;
    localparam int ACC_W      = 32;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [OP_W-1:0] {
        OP_IDLE    = 4'd0,
        OP_ADD     = 4'd1,
        OP_ADD_K   = 4'd2,
        OP_SUB     = 4'd3,
        OP_SUB_ABS = 4'd4,
        OP_MUL     = 4'd5,
        OP_MUL_K   = 4'd6,
        OP_LOAD    = 4'd7,
        OP_MAC     = 4'd8
    } t_op;

    // saturate a 32-bit signed value to 16 bits
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 32'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // opcodes that give a result word
    function automatic logic op_has_result(input logic [OP_W-1:0] op);
        logic res;
        case (op) inside
            OP_ADD, OP_ADD_K, OP_SUB, OP_SUB_ABS,
            OP_MUL, OP_MUL_K, OP_LOAD, OP_MAC: res = 1'b1;
            default:                            res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/qam_req_if.sv =====
// interface: request channel carrying opcode and two q8.8 operands
interface qam_req_if;
    import qam_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          req_type;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

// ===== rtl/qam_rsp_if.sv =====
// interface: result channel carrying one q8.8 value
interface qam_rsp_if;
    import qam_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;

    modport source (output valid, result_value, input ready);
    modport sink   (input valid, result_value, output ready);
endinterface

// ===== rtl/q88_saturating_alu_mac.sv =====
// top level: q8.8 saturating alu with 32-bit multiply-accumulate
// One request word enters per cycle as long as the result side keeps taking words. Each
// word is held in the input register, and its result word then lands in the output
// register, which drives the result channel.
// Idle and unused opcodes are consumed without producing a result. Add, subtract and
// subtract-absolute saturate to 16 bits; multiply gives (a*b) >>> FRAC_BITS (rounding
// toward minus infinity) saturated to 16 bits; load returns b; mac adds the shifted
// product to a 32-bit accumulator that saturates at 32 bits and returns the new
// accumulator saturated to 16 bits. The accumulator is cleared only by reset and is
// updated as the mac word leaves the input register, so back-to-back mac words chain
// without bubbles. The single 16x16 multiply feeding the 33-bit accumulate add sets the
// cycle time of this block.
module q88_saturating_alu_mac #(
    parameter int FRAC_BITS = qam_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qam_req_if.sink    i_req,
    qam_rsp_if.source  o_rsp
);
    import qam_pkg::*;

    // input register
    logic                     r_s1_valid;
    logic [OP_W-1:0]          r_s1_op;
    logic signed [DATA_W-1:0] r_s1_a;
    logic signed [DATA_W-1:0] r_s1_b;

    // accumulator and output register
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_result;
    logic signed [DATA_W-1:0] n_out_result;

    // handshake control
    logic w_produces;
    logic w_out_free;
    logic w_s1_go;
    logic w_in_ready;

    // datapath
    logic signed [ACC_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]  w_shp;
    logic signed [DATA_W:0]   w_sum;
    logic signed [DATA_W:0]   w_diff;
    logic signed [DATA_W+1:0] w_dext;
    logic signed [DATA_W+1:0] w_abs;
    logic signed [ACC_W:0]    w_acc_sum;

    assign w_produces = op_has_result(r_s1_op);
    assign w_out_free = !r_out_valid || o_rsp.ready;
    // an idle word drains without needing the output side
    assign w_s1_go    = r_s1_valid && (!w_produces || w_out_free);
    assign w_in_ready = !r_s1_valid || w_s1_go;

    assign i_req.ready        = w_in_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_s1_op <= i_req.req_type;
            r_s1_a  <= i_req.operand_a;
            r_s1_b  <= i_req.operand_b;
        end
    end

    // product fits 32 bits: worst case is (-2^15)^2 = 2^30
    assign w_prod = {{(ACC_W-DATA_W){r_s1_a[DATA_W-1]}}, r_s1_a}
                  * {{(ACC_W-DATA_W){r_s1_b[DATA_W-1]}}, r_s1_b};
    // arithmetic shift gives the floor, matching round toward minus infinity
    assign w_shp  = w_prod >>> FRAC_BITS;

    assign w_sum  = {r_s1_a[DATA_W-1], r_s1_a} + {r_s1_b[DATA_W-1], r_s1_b};
    assign w_diff = {r_s1_a[DATA_W-1], r_s1_a} - {r_s1_b[DATA_W-1], r_s1_b};
    assign w_dext = {w_diff[DATA_W], w_diff};
    assign w_abs  = w_dext[DATA_W+1] ? -w_dext : w_dext;

    assign w_acc_sum = {r_acc[ACC_W-1], r_acc} + {w_shp[ACC_W-1], w_shp};

    // 32-bit saturation of the accumulate: overflow when the two top bits differ
    always_comb begin
        if (w_acc_sum[ACC_W] != w_acc_sum[ACC_W-1]) begin
            n_acc = w_acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_acc = w_acc_sum[ACC_W-1:0];
        end
    end

    // result select
    always_comb begin
        unique case (r_s1_op)
            OP_ADD, OP_ADD_K: n_out_result = sat16(ACC_W'(w_sum));
            OP_SUB:           n_out_result = sat16(ACC_W'(w_diff));
            OP_SUB_ABS:       n_out_result = sat16(ACC_W'(w_abs));
            OP_MUL, OP_MUL_K: n_out_result = sat16(w_shp);
            OP_LOAD:          n_out_result = r_s1_b;
            OP_MAC:           n_out_result = sat16(n_acc);
            default:          n_out_result = r_s1_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_s1_go && (r_s1_op == OP_MAC)) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && w_produces) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && w_produces) begin
            r_out_result <= n_out_result;
        end
    end

    // accumulator moves only when a mac word leaves the input register
    a_acc_only_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_s1_go && (r_s1_op == OP_MAC)) |=> $stable(r_acc))
        else $error("accumulator changed without a mac word");

    // a new result word appears only from a word that produces one
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(w_s1_go && w_produces))
        else $error("result word without a producing request");

    // a mac result is the saturated view of the updated accumulator
    a_mac_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && (r_s1_op == OP_MAC)) |=> (r_out_result == sat16(r_acc)))
        else $error("mac result does not match accumulator");

endmodule

// ===== bench/q88_result_checker.sv =====
// checker: watches both channels, predicts each q8.8 result word and compares it
module q88_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    qam_req_if   req_mon,
    qam_rsp_if   rsp_mon,
    output int   o_mismatch_count,
    output int   o_words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import qam_pkg::*;

    logic signed [ACC_W-1:0]  acc_model;
    logic signed [DATA_W-1:0] pending_values[$];
    int                       mismatches;

    function automatic logic signed [DATA_W-1:0] clamp16(input longint v);
        logic signed [DATA_W-1:0] res;
        if (v > 32767) begin
            res = 16'sh7FFF;
        end else if (v < -32768) begin
            res = 16'sh8000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp32(input longint v);
        logic signed [ACC_W-1:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

    // arithmetic shift floors, matching the block's rounding toward minus infinity
    function automatic longint scaled_product(input logic signed [DATA_W-1:0] a,
                                              input logic signed [DATA_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC_BITS_DEF;
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] want;
        logic                     gives_word;
        longint                   diff;
        if (!i_rst_n) begin
            acc_model = '0;
            pending_values.delete();
        end else begin
            // a result word always belongs to an older request, so compare first
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (pending_values.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0d",
                             $time, rsp_mon.result_value);
                    mismatches++;
                end else begin
                    want = pending_values.pop_front();
                    if (rsp_mon.result_value !== want) begin
                        $display("%0t: result_value mismatch, expected %0d, actual %0d",
                                 $time, want, rsp_mon.result_value);
                        mismatches++;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                a          = req_mon.operand_a;
                b          = req_mon.operand_b;
                value      = '0;
                gives_word = 1'b1;
                case (req_mon.req_type)
                    OP_ADD, OP_ADD_K: value = clamp16(longint'(a) + longint'(b));
                    OP_SUB:           value = clamp16(longint'(a) - longint'(b));
                    OP_SUB_ABS: begin
                        diff = longint'(a) - longint'(b);
                        if (diff < 0) begin
                            diff = -diff;
                        end
                        value = clamp16(diff);
                    end
                    OP_MUL, OP_MUL_K: value = clamp16(scaled_product(a, b));
                    OP_LOAD:          value = b;
                    OP_MAC: begin
                        acc_model = clamp32(longint'(acc_model) + scaled_product(a, b));
                        value     = clamp16(longint'(acc_model));
                    end
                    default:          gives_word = 1'b0;
                endcase
                if (gives_word) begin
                    pending_values.push_back(value);
                end
            end
        end
        o_mismatch_count  <= mismatches;
        o_words_in_flight <= pending_values.size();
    end

endmodule

// ===== bench/tb_q88_saturating_alu_mac.sv =====
// testbench top: drives request words and result backpressure, watchdog and verdict
module tb_q88_saturating_alu_mac;
    timeunit 1ns;
    timeprecision 1ps;

    import qam_pkg::*;

    // codes outside the opcode list; the block must swallow them like idle
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    // random words beside the directed words and the two long mac clamp runs
    localparam int RANDOM_WORDS   = 200;
    localparam int PHASE_WORDS    = 150;
    localparam int DRAIN_CYCLES   = 12;
    // far above the longest legal quiet spell at 72% stall or idle
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;

    qam_req_if req_ch ();
    qam_rsp_if rsp_ch ();

    int mismatch_count;
    int words_in_flight;
    int quiet_cycles;
    int words_sent;
    int gap_pct;
    int stall_pct;

    // idling phases: none, sender idle, receiver stalling, both a little
    int gap_by_phase[4]   = '{0, 72, 0, 9};
    int stall_by_phase[4] = '{0, 0, 72, 9};

    q88_saturating_alu_mac DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    q88_result_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .req_mon           (req_ch),
        .rsp_mon           (rsp_ch),
        .o_mismatch_count  (mismatch_count),
        .o_words_in_flight (words_in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side backpressure, redrawn every cycle from the current phase
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: any cycle with no word moving on either channel counts
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // mostly full random, with a share of edge values to hit the clamps
    function automatic logic signed [DATA_W-1:0] pick_operand();
        logic signed [DATA_W-1:0] v;
        if ($urandom_range(99) < 20) begin
            case ($urandom_range(7))
                0:       v = 16'sh8000;
                1:       v = 16'sh8001;
                2:       v = 16'sh7FFF;
                3:       v = 16'sh0000;
                4:       v = 16'sh0001;
                5:       v = 16'shFFFF;
                6:       v = 16'sh0100;
                default: v = 16'shFF00;
            endcase
        end else begin
            v = DATA_W'($urandom);
        end
        return v;
    endfunction

    // real opcodes most of the time, idle and unused codes as noise
    function automatic logic [OP_W-1:0] pick_op();
        logic [OP_W-1:0] op;
        if ($urandom_range(99) < 8) begin
            if ($urandom_range(1) == 0) begin
                op = OP_IDLE;
            end else begin
                op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            end
        end else begin
            op = OP_W'($urandom_range(OP_MAC, OP_ADD));
        end
        return op;
    endfunction

    // present one request word, possibly after idle cycles, and hold it until taken;
    // valid is never dropped between back-to-back words
    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic signed [DATA_W-1:0] a,
                             input logic signed [DATA_W-1:0] b);
        while ($urandom_range(99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        words_sent++;
        gap_pct   = gap_by_phase[(words_sent / PHASE_WORDS) % 4];
        stall_pct = stall_by_phase[(words_sent / PHASE_WORDS) % 4];
    endtask

    // stop sending and let every outstanding result word come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_in_flight != 0) begin
            @(posedge i_clk);
        end
    endtask

    // long run of near-full-scale macs to drive the accumulator into a 32-bit clamp
    task automatic mac_saturation_run(input int count, input logic negative);
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        for (int i = 0; i < count; i++) begin
            a = 16'sh7F00 | DATA_W'($urandom_range(255));
            b = 16'sh7F00 | DATA_W'($urandom_range(255));
            if (negative) begin
                b = -b;
            end
            send_word(OP_MAC, a, b);
        end
    endtask

    initial begin : stimulus
        int regular_words;
        int run_len;
        bit clamps_done;
        bit mid_drain_done;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= OP_IDLE;
        req_ch.operand_a <= '0;
        req_ch.operand_b <= '0;
        words_sent       = 0;
        gap_pct          = 0;
        stall_pct        = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clamps on both sides, rounding, pass-through, swallowed codes
        send_word(OP_ADD,     16'sh7FFF, 16'sh0001);
        send_word(OP_ADD,     16'sh8000, 16'shFFFF);
        send_word(OP_ADD_K,   16'sh0100, 16'shFE00);
        send_word(OP_SUB,     16'sh8000, 16'sh0001);
        send_word(OP_SUB,     16'sh7FFF, 16'sh8000);
        send_word(OP_SUB_ABS, 16'sh8000, 16'sh7FFF);
        send_word(OP_SUB_ABS, 16'sh0005, 16'sh012C);
        send_word(OP_SUB_ABS, 16'sh8000, 16'sh8000);
        send_word(OP_MUL,     16'sh8000, 16'sh8000);
        send_word(OP_MUL,     16'sh8000, 16'sh7FFF);
        send_word(OP_MUL,     16'shFFFF, 16'sh0001);
        send_word(OP_MUL,     16'sh0180, 16'sh0180);
        send_word(OP_MUL_K,   16'sh0100, 16'shFF80);
        send_word(OP_LOAD,    16'sh007B, 16'sh8000);
        send_word(OP_LOAD,    16'sh8000, 16'sh7FFF);
        send_word(OP_IDLE,    16'sh7FFF, 16'sh7FFF);
        send_word(OP_UNUSED_LO, 16'sh1234, 16'sh5678);
        send_word(OP_UNUSED_HI, 16'shFFFF, 16'shFFFF);
        send_word(OP_MAC,     16'sh0100, 16'sh0100);
        send_word(OP_MAC,     16'shFFFF, 16'sh0001);
        send_word(OP_MAC,     16'sh8000, 16'sh8000);
        send_word(OP_MAC,     16'sh8000, 16'sh7FFF);
        send_word(OP_MAC,     16'sh0000, 16'sh0000);

        // pressure point: sender holds off until nothing is outstanding
        drain_results();

        regular_words  = 0;
        clamps_done    = 1'b0;
        mid_drain_done = 1'b0;
        while (regular_words < RANDOM_WORDS) begin
            if (!clamps_done && regular_words >= RANDOM_WORDS / 3) begin
                // push up into the upper clamp and sit there a while,
                // then from the top all the way down into the lower clamp
                mac_saturation_run(560, 1'b0);
                mac_saturation_run(1050, 1'b1);
                clamps_done = 1'b1;
            end else if (!mid_drain_done && regular_words >= RANDOM_WORDS / 2) begin
                drain_results();
                mid_drain_done = 1'b1;
            end else if ($urandom_range(99) < 12) begin
                // chained macs with random content
                run_len = $urandom_range(30, 2);
                for (int i = 0; i < run_len; i++) begin
                    send_word(OP_MAC, pick_operand(), pick_operand());
                end
                regular_words += run_len;
            end else begin
                send_word(pick_op(), pick_operand(), pick_operand());
                regular_words++;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && words_in_flight == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
